/* rtl/tvpj_pkg.sv */
// ----------------------------------------------------------------------------
// tvpj_pkg
// Shared types, constants and helpers for the three-view projection Jacobian.
// ----------------------------------------------------------------------------
`default_nettype none

package tvpj_pkg;

  localparam int NUM_VIEWS      = 3;
  localparam int FRAC_BITS      = 16;
  localparam int COEFS_PER_VIEW = 12;
  localparam int NUM_COEFS      = NUM_VIEWS * COEFS_PER_VIEW;
  localparam int VIEW_W         = 2;
  localparam int IDX_W          = 6;
  localparam int NUM_W          = 50;
  localparam int DVD_W          = NUM_W + FRAC_BITS;
  localparam int QCNT_W         = $clog2(DVD_W + 1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] point_w;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         view_sel;
    logic               axis_sel;
    logic [1:0]         column_sel;
    logic signed [31:0] proj_value;
    logic signed [31:0] d_point;
    logic signed [31:0] d_own_row;
    logic signed [31:0] d_depth_row;
    logic               zero_depth;
    logic               last_flag;
  } out_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } div_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW_RD,
    S_ROW_MUL,
    S_ROW_ACC,
    S_QDIV,
    S_QWAIT,
    S_ODIV,
    S_OWAIT,
    S_J_RD2,
    S_J_RD1,
    S_J_NUM,
    S_J_DWAIT,
    S_J_DEP,
    S_J_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tvpj_mul.sv */
// ----------------------------------------------------------------------------
// tvpj_mul
// Shared signed 32x32 multiplier with registered product and capture enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tvpj_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p_r
);
  import tvpj_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

`default_nettype wire

/* rtl/tvpj_div.sv */
// ----------------------------------------------------------------------------
// tvpj_div
// Bit-serial signed divider: trunc(num * 2^FRAC_BITS / den), saturated to 32.
// ----------------------------------------------------------------------------
`default_nettype none

module tvpj_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tvpj_pkg::div_cmd_t  cmd,
  output logic                     done_r,
  output logic signed [31:0]       quo_r
);
  import tvpj_pkg::*;

  logic              busy_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  acc_r;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  ad_r;
  logic              neg_r;

  logic [NUM_W-1:0]  an;
  logic [NUM_W-1:0]  dn;
  logic [NUM_W:0]    rem_s;
  logic              qbit;
  logic [NUM_W:0]    rem_d;
  logic [NUM_W-1:0]  rem_nxt;
  logic [DVD_W-1:0]  acc_nxt;
  logic [31:0]       limit;
  logic              ovf;
  logic signed [31:0] res_nxt;

  always_comb begin
    an      = cmd.num[NUM_W-1] ? NUM_W'(-cmd.num) : NUM_W'(cmd.num);
    dn      = cmd.den[NUM_W-1] ? NUM_W'(-cmd.den) : NUM_W'(cmd.den);
    rem_s   = {rem_r, dvd_r[DVD_W-1]};
    qbit    = (rem_s >= {1'b0, ad_r});
    rem_d   = rem_s - {1'b0, ad_r};
    rem_nxt = qbit ? rem_d[NUM_W-1:0] : rem_s[NUM_W-1:0];
    acc_nxt = {acc_r[DVD_W-2:0], qbit};
    limit   = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    ovf     = (|acc_nxt[DVD_W-1:32]) || (acc_nxt[31:0] > limit);
    if (ovf) begin
      res_nxt = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res_nxt = neg_r ? -$signed(acc_nxt[31:0]) : $signed(acc_nxt[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        if (cmd.den == '0) begin
          done_r <= 1'b1;
          if (cmd.num > 0) begin
            quo_r <= 32'sh7FFF_FFFF;
          end else if (cmd.num < 0) begin
            quo_r <= 32'sh8000_0000;
          end else begin
            quo_r <= '0;
          end
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          dvd_r  <= {an, {FRAC_BITS{1'b0}}};
          acc_r  <= '0;
          rem_r  <= '0;
          ad_r   <= dn;
          neg_r  <= cmd.num[NUM_W-1] ^ cmd.den[NUM_W-1];
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == QCNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quo_r  <= res_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/three_view_projection_jacobian.sv */
// ----------------------------------------------------------------------------
// three_view_projection_jacobian
// Projects a homogeneous point through three stored 3x4 matrices and emits
// the projected coordinates with their Jacobian entries.
// ----------------------------------------------------------------------------
// A load request writes one coefficient when it is accepted. A point request
// is worked by a small sequencer around one shared 32x32 multiplier and one
// bit-serial divider. Each view needs 12 products for its rows and 14
// divisions; a division by a zero depth skips the bit-serial run, so such a
// view finishes far sooner. An output stall holds the sequencer in its emit
// state. in_stall is high for the whole run and the 24 results leave through
// an output register.
`default_nettype none

module three_view_projection_jacobian (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tvpj_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tvpj_pkg::out_req_t      out_req
);
  import tvpj_pkg::*;

  state_t state_r, state_nxt;

  logic [VIEW_W-1:0]       view_r;
  logic [1:0]              row_r;
  logic [1:0]              col_r;
  logic                    axis_r;
  logic signed [31:0]      x_r [4];
  logic signed [NUM_W-1:0] acc_r;
  logic signed [NUM_W-1:0] rows_r [3];
  logic signed [31:0]      q_r [2];
  logic signed [31:0]      own_r [4];
  logic signed [31:0]      dp_r;
  logic                    out_valid_r;
  out_req_t                out_r;

  logic [31:0]      coef_mem [NUM_COEFS];
  logic signed [31:0] mem_q_r;
  logic [IDX_W-1:0] rd_addr;
  logic [1:0]       rd_row;

  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] shr;
  logic signed [NUM_W-1:0] term;
  logic signed [NUM_W-1:0] num_c;

  div_cmd_t           div_cmd;
  logic               div_done;
  logic signed [31:0] div_quo;

  logic in_acc, out_free, emit;

  tvpj_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  tvpj_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (div_cmd),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_req   = out_r;
  assign out_free  = !(out_valid_r && out_stall);

  assign shr   = mul_p >>> FRAC_BITS;
  assign term  = shr[NUM_W-1:0];
  assign num_c = {{(NUM_W-32){mem_q_r[31]}}, mem_q_r} - term;

  // coefficient store
  always_comb begin
    rd_row  = (state_r == S_J_RD1) ? {1'b0, axis_r}
            : (state_r == S_J_RD2) ? 2'd2 : row_r;
    rd_addr = IDX_W'(view_r * COEFS_PER_VIEW) + IDX_W'({rd_row, 2'b00}) + IDX_W'(col_r);
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req.req_type == REQ_LOAD && in_req.coef_index < IDX_W'(NUM_COEFS)) begin
      coef_mem[in_req.coef_index] <= in_req.coef_value;
    end
    mem_q_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mul_en        = 1'b0;
    mul_a         = mem_q_r;
    mul_b         = x_r[col_r];
    div_cmd.start = 1'b0;
    div_cmd.num   = rows_r[axis_r];
    div_cmd.den   = rows_r[2];
    emit          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_req.req_type == REQ_POINT) begin
          state_nxt = S_ROW_RD;
        end
      end
      S_ROW_RD:  state_nxt = S_ROW_MUL;
      S_ROW_MUL: begin
        mul_en    = 1'b1;
        state_nxt = S_ROW_ACC;
      end
      S_ROW_ACC: begin
        if (col_r == 2'd3 && row_r == 2'd2) begin
          state_nxt = S_QDIV;
        end else begin
          state_nxt = S_ROW_RD;
        end
      end
      S_QDIV: begin
        div_cmd.start = 1'b1;
        state_nxt     = S_QWAIT;
      end
      S_QWAIT: begin
        if (div_done) begin
          state_nxt = axis_r ? S_ODIV : S_QDIV;
        end
      end
      S_ODIV: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = {{(NUM_W-32){x_r[col_r][31]}}, x_r[col_r]};
        state_nxt     = S_OWAIT;
      end
      S_OWAIT: begin
        if (div_done) begin
          state_nxt = (col_r == 2'd3) ? S_J_RD2 : S_ODIV;
        end
      end
      S_J_RD2: state_nxt = S_J_RD1;
      S_J_RD1: begin
        mul_en    = 1'b1;
        mul_b     = q_r[axis_r];
        state_nxt = S_J_NUM;
      end
      S_J_NUM: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = num_c;
        state_nxt     = S_J_DWAIT;
      end
      S_J_DWAIT: begin
        if (div_done) begin
          state_nxt = S_J_DEP;
        end
      end
      S_J_DEP: begin
        mul_en    = 1'b1;
        mul_a     = own_r[col_r];
        mul_b     = q_r[axis_r];
        state_nxt = S_J_EMIT;
      end
      S_J_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (col_r != 2'd3 || !axis_r) begin
            state_nxt = S_J_RD2;
          end else if (view_r == VIEW_W'(NUM_VIEWS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ROW_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    unique case (state_r)
      S_IDLE: begin
        view_r <= '0;
        row_r  <= '0;
        col_r  <= '0;
        axis_r <= 1'b0;
        acc_r  <= '0;
        x_r[0] <= in_req.point_x;
        x_r[1] <= in_req.point_y;
        x_r[2] <= in_req.point_z;
        x_r[3] <= in_req.point_w;
      end
      S_ROW_ACC: begin
        if (col_r == 2'd3) begin
          rows_r[row_r] <= acc_r + term;
          acc_r         <= '0;
          col_r         <= '0;
          row_r         <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
          axis_r        <= 1'b0;
        end else begin
          acc_r <= acc_r + term;
          col_r <= col_r + 2'd1;
        end
      end
      S_QWAIT: begin
        if (div_done) begin
          q_r[axis_r] <= div_quo;
          axis_r      <= !axis_r;
          col_r       <= '0;
        end
      end
      S_OWAIT: begin
        if (div_done) begin
          own_r[col_r] <= div_quo;
          col_r        <= col_r + 2'd1;
          axis_r       <= 1'b0;
        end
      end
      S_J_DWAIT: begin
        if (div_done) begin
          dp_r <= div_quo;
        end
      end
      S_J_EMIT: begin
        if (out_free) begin
          out_r.view_sel    <= 2'(view_r);
          out_r.axis_sel    <= axis_r;
          out_r.column_sel  <= col_r;
          out_r.proj_value  <= q_r[axis_r];
          out_r.d_point     <= dp_r;
          out_r.d_own_row   <= own_r[col_r];
          out_r.d_depth_row <= sat32(-shr);
          out_r.zero_depth  <= (rows_r[2] == '0);
          out_r.last_flag   <= (view_r == VIEW_W'(NUM_VIEWS - 1)) && axis_r && (col_r == 2'd3);
          col_r             <= col_r + 2'd1;
          if (col_r == 2'd3) begin
            axis_r <= !axis_r;
            if (axis_r) begin
              view_r <= view_r + 1'b1;
              row_r  <= '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_QWAIT || state_r == S_OWAIT || state_r == S_J_DWAIT))
    else $error("divider result outside a wait state");

  a_idle_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_cmd.start)
    else $error("divider started while idle");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (state_nxt == S_IDLE) |=> out_valid_r && out_r.last_flag)
    else $error("final request of a point not flagged");

endmodule

`default_nettype wire
